FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with active-low reset disable.
`define TGDT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication held on every rising clock edge outside reset.
`define TGDT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  `TGDT_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

FILE: rtl/tgdt_pkg.sv
// Shared types, constants and tables of the gesture direction tracker.
package tgdt_pkg;

  localparam int MAX_FINGERS = 4;
  localparam int MAX_MOVES   = 16;
  localparam int ZONES       = 8;

  localparam logic [3:0] NO_ZONE     = 4'd15;
  localparam logic [3:0] MOVE_PINCH  = 4'd8;
  localparam logic [3:0] MOVE_EXPAND = 4'd9;

  localparam logic [2:0] REG_TOL    = 3'd0;
  localparam logic [2:0] REG_MINIT  = 3'd1;
  localparam logic [2:0] REG_FACTOR = 3'd2;
  localparam logic [2:0] REG_MDIST  = 3'd3;
  localparam logic [2:0] REG_ARC    = 3'd4;

  localparam logic [25:0] DEG90  = 26'd5898240;
  localparam logic [25:0] DEG180 = 26'd11796480;
  localparam logic [25:0] DEG360 = 26'd23592960;
  localparam logic [25:0] DEG45  = 26'd2949120;
  localparam logic [25:0] DEG135 = 26'd8847360;
  localparam logic [25:0] DEG225 = 26'd14745600;
  localparam logic [25:0] DEG315 = 26'd20643840;

  localparam logic [4:0] CORDIC_LAST = 5'd15;
  localparam logic [4:0] SQRT_LAST   = 5'd23;
  localparam logic [4:0] DIV_LAST    = 5'd24;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_CLEAR, OP_SKIP_INIT, OP_SKIP_MUL, OP_SKIP_INC,
    OP_TV_DIFF, OP_SQ, OP_SUM, OP_TV_M1, OP_TV_M2, OP_TV_CMP,
    OP_ZN_DIFF, OP_CD_INIT, OP_CD_ITER, OP_CD_FIN, OP_ZN_SET,
    OP_COMMIT, OP_SP_INIT, OP_SP_DIFF, OP_SQ_INIT, OP_SQ_ITER, OP_SP_ACC,
    OP_DIV_INIT, OP_DIV_ITER, OP_PX_M, OP_DECIDE, OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_SKMUL, S_SKTEST, S_TV_DIFF, S_TV_SQ, S_TV_SUM,
    S_TV_M1, S_TV_M2, S_TV_CMP, S_TV_END, S_ZN_DIFF, S_CD_INIT, S_CD_ITER,
    S_CD_FIN, S_ZN_SET, S_COMMIT, S_SP_INIT, S_SP_DIFF, S_SP_SQ, S_SP_SUM,
    S_SQ_INIT, S_SQ_ITER, S_SP_ACC, S_DIV_INIT, S_DIV_ITER, S_PX_M,
    S_DECIDE, S_EMIT
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] fi;
    logic [4:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic       clear;
    logic [2:0] c;
    logic [2:0] h;
    logic [2:0] m;
    logic       skip_hold;
    logic       moved;
    logic       out_free;
  } dp_status_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_step(input logic [3:0] i);
    logic [21:0] v;
    unique case (i)
      4'd0:  v = 22'd2949120;
      4'd1:  v = 22'd1740967;
      4'd2:  v = 22'd919879;
      4'd3:  v = 22'd466945;
      4'd4:  v = 22'd234379;
      4'd5:  v = 22'd117304;
      4'd6:  v = 22'd58666;
      4'd7:  v = 22'd29333;
      4'd8:  v = 22'd14668;
      4'd9:  v = 22'd7334;
      4'd10: v = 22'd3667;
      4'd11: v = 22'd1833;
      4'd12: v = 22'd917;
      4'd13: v = 22'd458;
      4'd14: v = 22'd229;
      default: v = 22'd115;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/tgdt_datapath.sv
// Datapath: tracking state, shared arithmetic units and the result register.
module tgdt_datapath #(
  parameter int MAX_MOVES = tgdt_pkg::MAX_MOVES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tgdt_pkg::dp_cmd_t   cmd,
  output tgdt_pkg::dp_status_t status,
  input  logic                in_cmd,
  input  logic [130:0]        in_frame,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [9:0]          cfg_wdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [47:0]         out_tdata
);
  localparam int CW = $clog2(MAX_MOVES + 1);
  localparam logic [3:0] NO_ZONE_C = tgdt_pkg::NO_ZONE;

  logic [6:0] tol_r, arc_r;
  logic [7:0] minit_r, factor_r;
  logic [9:0] mdist_r;

  logic        clear_r;
  logic [2:0]  c_r, hist_r;
  logic [15:0] fx_r [4];
  logic [15:0] fy_r [4];
  logic [15:0] px_r [4];
  logic [15:0] py_r [4];
  logic [3:0]  zone_r [4];
  logic [CW-1:0] mcount_r;
  logic [3:0]  last_move_r;
  logic [23:0] pmean_r;
  logic [15:0] skip_r;
  logic [15:0] start_x_r, start_y_r;

  logic [47:0] num_r;
  logic [50:0] den_r;
  logic [51:0] lim_r;
  logic        moved_r;
  logic signed [16:0] dx_r, dy_r;
  logic [31:0] sqx_r, sqy_r;
  logic [32:0] sq_r;
  logic [52:0] prod_r;
  logic signed [32:0] cx_r, cy_r;
  logic signed [25:0] cz_r;
  logic        axz_r, ayz_r, dxn_r, dyn_r;
  logic [25:0] theta_r;
  logic [47:0] val_r;
  logic [26:0] rem_r;
  logic [23:0] root_r;
  logic [24:0] sum_r, q_r;
  logic [1:0]  dr_r;
  logic [30:0] pa_r;
  logic [31:0] pb_r, pc_r;
  logic        acc_r, valid_r, full_r;
  logic [3:0]  move_out_r;
  logic        ov_r;
  logic [47:0] od_r;

  logic [2:0]  m_c;
  logic [3:0]  single;
  logic        single_ok;
  logic [6:0]  tol_c, arc_c;
  logic [25:0] half;
  logic [3:0]  zone_n;
  logic [25:0] phi, theta_c;
  logic signed [25:0] czc;
  logic signed [32:0] xs, ys;
  logic [26:0] rem_sh, trial;
  logic [3:0]  move_d;
  logic        move_ok;
  logic [1:0]  fj;
  logic [15:0] ax, ay;

  assign m_c = (c_r < hist_r) ? c_r : hist_r;
  assign tol_c = (tol_r > 7'd100) ? 7'd100 : tol_r;
  assign arc_c = (arc_r > 7'd90) ? 7'd90 : arc_r;
  assign half = {4'd0, arc_c, 15'd0};
  assign fj = cmd.fi + 2'd1;
  assign ax = dx_r[16] ? 16'(-dx_r) : dx_r[15:0];
  assign ay = dy_r[16] ? 16'(-dy_r) : dy_r[15:0];
  assign xs = cx_r >>> cmd.step[3:0];
  assign ys = cy_r >>> cmd.step[3:0];
  assign rem_sh = {rem_r[24:0], val_r[47:46]};
  assign trial = {1'b0, root_r, 2'b01};

  always_comb begin
    single = NO_ZONE_C;
    single_ok = 1'b0;
    for (int i = 0; i < tgdt_pkg::MAX_FINGERS; i++) begin
      if (3'(i) < c_r && zone_r[i] != tgdt_pkg::NO_ZONE) begin
        single = zone_r[i];
        single_ok = 1'b1;
      end
    end
  end

  // zone = number of boundaries at or below the angle, modulo eight
  always_comb begin
    logic [3:0] n;
    n = 4'd0;
    if (tgdt_pkg::DEG45 - half <= theta_r) n = n + 4'd1;
    if (tgdt_pkg::DEG45 + half <= theta_r) n = n + 4'd1;
    if (tgdt_pkg::DEG135 - half <= theta_r) n = n + 4'd1;
    if (tgdt_pkg::DEG135 + half <= theta_r) n = n + 4'd1;
    if (tgdt_pkg::DEG225 - half <= theta_r) n = n + 4'd1;
    if (tgdt_pkg::DEG225 + half <= theta_r) n = n + 4'd1;
    if (tgdt_pkg::DEG315 - half <= theta_r) n = n + 4'd1;
    if (tgdt_pkg::DEG315 + half <= theta_r) n = n + 4'd1;
    zone_n = {1'b0, n[2:0]};
  end

  always_comb begin
    czc = cz_r;
    if (cz_r < 26'sd0) czc = 26'sd0;
    if (cz_r > $signed(tgdt_pkg::DEG90)) czc = $signed(tgdt_pkg::DEG90);
    if (ayz_r) phi = 26'd0;
    else if (axz_r) phi = tgdt_pkg::DEG90;
    else phi = czc;
    if (!dxn_r && !dyn_r) theta_c = phi;
    else if (dxn_r && !dyn_r) theta_c = tgdt_pkg::DEG180 - phi;
    else if (dxn_r) theta_c = tgdt_pkg::DEG180 + phi;
    else theta_c = tgdt_pkg::DEG360 - phi;
    if (theta_c >= tgdt_pkg::DEG360) theta_c = theta_c - tgdt_pkg::DEG360;
  end

  always_comb begin
    move_d = single;
    move_ok = 1'b0;
    if (c_r == 3'd1) begin
      move_ok = single_ok;
    end else if (c_r != 3'd0 && pmean_r != 24'd0) begin
      if (32'(pa_r) > pb_r) begin
        move_d = tgdt_pkg::MOVE_EXPAND;
        move_ok = 1'b1;
      end else if (32'(pa_r) < pc_r) begin
        move_d = tgdt_pkg::MOVE_PINCH;
        move_ok = 1'b1;
      end else begin
        move_ok = single_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 7'd15; minit_r <= 8'd12; factor_r <= 8'd110;
      mdist_r <= 10'd16; arc_r <= 7'd22;
      hist_r <= 3'd0; mcount_r <= '0; pmean_r <= 24'd0; skip_r <= 16'd0;
      start_x_r <= 16'd0; start_y_r <= 16'd0; ov_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        px_r[i] <= 16'd0; py_r[i] <= 16'd0; zone_r[i] <= tgdt_pkg::NO_ZONE;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          tgdt_pkg::REG_TOL:    tol_r <= cfg_wdata[6:0];
          tgdt_pkg::REG_MINIT:  minit_r <= cfg_wdata[7:0];
          tgdt_pkg::REG_FACTOR: factor_r <= cfg_wdata[7:0];
          tgdt_pkg::REG_MDIST:  mdist_r <= cfg_wdata;
          tgdt_pkg::REG_ARC:    arc_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (cmd.op == tgdt_pkg::OP_EMIT) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      unique case (cmd.op)
        tgdt_pkg::OP_LOAD: begin
          clear_r <= in_cmd;
          c_r <= (in_frame[2:0] > 3'd4) ? 3'd4 : in_frame[2:0];
          for (int i = 0; i < 4; i++) begin
            fx_r[i] <= in_frame[3 + 32*i +: 16];
            fy_r[i] <= in_frame[19 + 32*i +: 16];
          end
          acc_r <= 1'b0; valid_r <= 1'b0; full_r <= 1'b0; move_out_r <= 4'd0;
        end
        tgdt_pkg::OP_CLEAR: begin
          hist_r <= 3'd0; mcount_r <= '0; pmean_r <= 24'd0; skip_r <= 16'd0;
          for (int i = 0; i < 4; i++) begin
            px_r[i] <= 16'd0; py_r[i] <= 16'd0; zone_r[i] <= tgdt_pkg::NO_ZONE;
          end
        end
        tgdt_pkg::OP_SKIP_INIT: begin
          num_r <= {40'd0, minit_r};
          den_r <= {35'd0, skip_r};
          lim_r <= {20'({10'd0, mdist_r} * {10'd0, mdist_r}), 32'd0};
          moved_r <= 1'b0;
        end
        tgdt_pkg::OP_SKIP_MUL: begin
          num_r <= 48'(num_r * factor_r);
          den_r <= 51'(den_r * 7'd100);
        end
        tgdt_pkg::OP_SKIP_INC: if (skip_r != 16'hFFFF) skip_r <= skip_r + 16'd1;
        tgdt_pkg::OP_TV_DIFF: begin
          dx_r <= $signed({1'b0, fx_r[cmd.fi]}) - $signed({1'b0, px_r[cmd.fi]});
          dy_r <= $signed({1'b0, fy_r[cmd.fi]}) - $signed({1'b0, py_r[cmd.fi]});
        end
        tgdt_pkg::OP_SQ: begin
          sqx_r <= 32'(dx_r * dx_r);
          sqy_r <= 32'(dy_r * dy_r);
        end
        tgdt_pkg::OP_SUM: sq_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
        tgdt_pkg::OP_TV_M1: prod_r <= 53'(sq_r * 10'd1000);
        tgdt_pkg::OP_TV_M2: prod_r <= 53'(prod_r[42:0] * 10'd1000);
        tgdt_pkg::OP_TV_CMP: if (prod_r > 53'(lim_r)) moved_r <= 1'b1;
        tgdt_pkg::OP_ZN_DIFF: begin
          dx_r <= $signed({1'b0, fx_r[cmd.fi]}) - $signed({1'b0, px_r[cmd.fi]});
          dy_r <= $signed({1'b0, py_r[cmd.fi]}) - $signed({1'b0, fy_r[cmd.fi]});
        end
        tgdt_pkg::OP_CD_INIT: begin
          cx_r <= $signed({3'd0, ax, 14'd0});
          cy_r <= $signed({3'd0, ay, 14'd0});
          cz_r <= 26'sd0;
          axz_r <= (ax == 16'd0); ayz_r <= (ay == 16'd0);
          dxn_r <= dx_r[16]; dyn_r <= dy_r[16];
        end
        tgdt_pkg::OP_CD_ITER: begin
          if (cy_r >= 33'sd0) begin
            cx_r <= cx_r + ys; cy_r <= cy_r - xs;
            cz_r <= cz_r + $signed({4'd0, tgdt_pkg::atan_step(cmd.step[3:0])});
          end else begin
            cx_r <= cx_r - ys; cy_r <= cy_r + xs;
            cz_r <= cz_r - $signed({4'd0, tgdt_pkg::atan_step(cmd.step[3:0])});
          end
        end
        tgdt_pkg::OP_CD_FIN: theta_r <= theta_c;
        tgdt_pkg::OP_ZN_SET: zone_r[cmd.fi] <= zone_n;
        tgdt_pkg::OP_COMMIT: begin
          if (hist_r == 3'd0 && c_r != 3'd0) begin
            start_x_r <= fx_r[0]; start_y_r <= fy_r[0];
          end
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < c_r) begin
              px_r[i] <= fx_r[i]; py_r[i] <= fy_r[i];
            end
            if (3'(i) >= m_c) zone_r[i] <= tgdt_pkg::NO_ZONE;
          end
          hist_r <= c_r;
        end
        tgdt_pkg::OP_SP_INIT: sum_r <= 25'd0;
        tgdt_pkg::OP_SP_DIFF: begin
          dx_r <= $signed({1'b0, px_r[cmd.fi]}) - $signed({1'b0, px_r[fj]});
          dy_r <= $signed({1'b0, py_r[cmd.fi]}) - $signed({1'b0, py_r[fj]});
        end
        tgdt_pkg::OP_SQ_INIT: begin
          val_r <= {3'd0, sq_r, 12'd0};
          rem_r <= 27'd0;
          root_r <= 24'd0;
        end
        tgdt_pkg::OP_SQ_ITER: begin
          if (rem_sh >= trial) begin
            rem_r <= rem_sh - trial;
            root_r <= {root_r[22:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            root_r <= {root_r[22:0], 1'b0};
          end
          val_r <= {val_r[45:0], 2'd0};
        end
        tgdt_pkg::OP_SP_ACC: sum_r <= sum_r + {1'b0, root_r};
        tgdt_pkg::OP_DIV_INIT: begin
          q_r <= sum_r;
          dr_r <= 2'd0;
        end
        tgdt_pkg::OP_DIV_ITER: begin
          if ({dr_r, q_r[24]} >= {1'b0, 2'(c_r - 3'd1)}) begin
            dr_r <= 2'({dr_r, q_r[24]} - {1'b0, 2'(c_r - 3'd1)});
            q_r <= {q_r[23:0], 1'b1};
          end else begin
            dr_r <= {dr_r[0], q_r[24]};
            q_r <= {q_r[23:0], 1'b0};
          end
        end
        tgdt_pkg::OP_PX_M: begin
          pa_r <= 31'(q_r[23:0] * 7'd100);
          pb_r <= 32'(pmean_r * (8'd100 + {1'b0, tol_c}));
          pc_r <= 32'(pmean_r * (8'd100 - {1'b0, tol_c}));
        end
        tgdt_pkg::OP_DECIDE: begin
          if (c_r == 3'd1) begin
            if (!single_ok) pmean_r <= 24'd0;
          end else if (c_r != 3'd0) begin
            pmean_r <= q_r[23:0];
          end
          skip_r <= 16'd0;
          acc_r <= 1'b1;
          if (move_ok && (mcount_r == '0 || last_move_r != move_d)) begin
            if (mcount_r < CW'(MAX_MOVES)) begin
              mcount_r <= mcount_r + CW'(1);
              last_move_r <= move_d;
              valid_r <= 1'b1;
              move_out_r <= move_d;
            end else begin
              full_r <= 1'b1;
            end
          end
        end
        tgdt_pkg::OP_EMIT: begin
          od_r <= {1'b0, full_r, 5'(mcount_r), start_y_r, start_x_r, hist_r,
                   move_out_r, valid_r, acc_r};
        end
        default: ;
      endcase
    end
  end

  assign status.clear = clear_r;
  assign status.c = c_r;
  assign status.h = hist_r;
  assign status.m = m_c;
  assign status.skip_hold = (den_r < {3'd0, num_r});
  assign status.moved = moved_r;
  assign status.out_free = !ov_r || out_tready;

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
endmodule

FILE: rtl/tgdt_ctrl.sv
// Sequencer that walks one request through the datapath steps.
module tgdt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  tgdt_pkg::dp_status_t status,
  output tgdt_pkg::dp_cmd_t    cmd
);
  tgdt_pkg::state_t state_r, state_nxt;
  logic [1:0] fi_r, fi_nxt;
  logic [4:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tgdt_pkg::S_IDLE;
      fi_r <= 2'd0;
      step_r <= 5'd0;
    end else begin
      state_r <= state_nxt;
      fi_r <= fi_nxt;
      step_r <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fi_nxt = fi_r;
    step_nxt = step_r;
    cmd.op = tgdt_pkg::OP_NOP;
    cmd.fi = fi_r;
    cmd.step = step_r;
    in_tready = 1'b0;
    unique case (state_r)
      tgdt_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = tgdt_pkg::OP_LOAD;
          state_nxt = tgdt_pkg::S_START;
        end
      end
      tgdt_pkg::S_START: begin
        step_nxt = 5'd0;
        if (status.clear) begin
          cmd.op = tgdt_pkg::OP_CLEAR;
          state_nxt = tgdt_pkg::S_EMIT;
        end else begin
          cmd.op = tgdt_pkg::OP_SKIP_INIT;
          state_nxt = tgdt_pkg::S_SKMUL;
        end
      end
      tgdt_pkg::S_SKMUL: begin
        cmd.op = tgdt_pkg::OP_SKIP_MUL;
        step_nxt = step_r + 5'd1;
        if (step_r == {2'd0, status.h}) state_nxt = tgdt_pkg::S_SKTEST;
      end
      tgdt_pkg::S_SKTEST: begin
        fi_nxt = 2'd0;
        if (status.skip_hold) begin
          cmd.op = tgdt_pkg::OP_SKIP_INC;
          state_nxt = tgdt_pkg::S_EMIT;
        end else if (status.h == 3'd0) state_nxt = tgdt_pkg::S_COMMIT;
        else if (status.m == 3'd0) state_nxt = tgdt_pkg::S_EMIT;
        else state_nxt = tgdt_pkg::S_TV_DIFF;
      end
      tgdt_pkg::S_TV_DIFF: begin
        cmd.op = tgdt_pkg::OP_TV_DIFF;
        state_nxt = tgdt_pkg::S_TV_SQ;
      end
      tgdt_pkg::S_TV_SQ: begin
        cmd.op = tgdt_pkg::OP_SQ;
        state_nxt = tgdt_pkg::S_TV_SUM;
      end
      tgdt_pkg::S_TV_SUM: begin
        cmd.op = tgdt_pkg::OP_SUM;
        state_nxt = tgdt_pkg::S_TV_M1;
      end
      tgdt_pkg::S_TV_M1: begin
        cmd.op = tgdt_pkg::OP_TV_M1;
        state_nxt = tgdt_pkg::S_TV_M2;
      end
      tgdt_pkg::S_TV_M2: begin
        cmd.op = tgdt_pkg::OP_TV_M2;
        state_nxt = tgdt_pkg::S_TV_CMP;
      end
      tgdt_pkg::S_TV_CMP: begin
        cmd.op = tgdt_pkg::OP_TV_CMP;
        if ({1'b0, fi_r} == status.m - 3'd1) begin
          fi_nxt = 2'd0;
          state_nxt = tgdt_pkg::S_TV_END;
        end else begin
          fi_nxt = fi_r + 2'd1;
          state_nxt = tgdt_pkg::S_TV_DIFF;
        end
      end
      tgdt_pkg::S_TV_END:
        state_nxt = status.moved ? tgdt_pkg::S_ZN_DIFF : tgdt_pkg::S_EMIT;
      tgdt_pkg::S_ZN_DIFF: begin
        cmd.op = tgdt_pkg::OP_ZN_DIFF;
        state_nxt = tgdt_pkg::S_CD_INIT;
      end
      tgdt_pkg::S_CD_INIT: begin
        cmd.op = tgdt_pkg::OP_CD_INIT;
        step_nxt = 5'd0;
        state_nxt = tgdt_pkg::S_CD_ITER;
      end
      tgdt_pkg::S_CD_ITER: begin
        cmd.op = tgdt_pkg::OP_CD_ITER;
        step_nxt = step_r + 5'd1;
        if (step_r == tgdt_pkg::CORDIC_LAST) state_nxt = tgdt_pkg::S_CD_FIN;
      end
      tgdt_pkg::S_CD_FIN: begin
        cmd.op = tgdt_pkg::OP_CD_FIN;
        state_nxt = tgdt_pkg::S_ZN_SET;
      end
      tgdt_pkg::S_ZN_SET: begin
        cmd.op = tgdt_pkg::OP_ZN_SET;
        if ({1'b0, fi_r} == status.m - 3'd1) state_nxt = tgdt_pkg::S_COMMIT;
        else begin
          fi_nxt = fi_r + 2'd1;
          state_nxt = tgdt_pkg::S_ZN_DIFF;
        end
      end
      tgdt_pkg::S_COMMIT: begin
        cmd.op = tgdt_pkg::OP_COMMIT;
        state_nxt = (status.c >= 3'd2) ? tgdt_pkg::S_SP_INIT : tgdt_pkg::S_DECIDE;
      end
      tgdt_pkg::S_SP_INIT: begin
        cmd.op = tgdt_pkg::OP_SP_INIT;
        fi_nxt = 2'd0;
        state_nxt = tgdt_pkg::S_SP_DIFF;
      end
      tgdt_pkg::S_SP_DIFF: begin
        cmd.op = tgdt_pkg::OP_SP_DIFF;
        state_nxt = tgdt_pkg::S_SP_SQ;
      end
      tgdt_pkg::S_SP_SQ: begin
        cmd.op = tgdt_pkg::OP_SQ;
        state_nxt = tgdt_pkg::S_SP_SUM;
      end
      tgdt_pkg::S_SP_SUM: begin
        cmd.op = tgdt_pkg::OP_SUM;
        state_nxt = tgdt_pkg::S_SQ_INIT;
      end
      tgdt_pkg::S_SQ_INIT: begin
        cmd.op = tgdt_pkg::OP_SQ_INIT;
        step_nxt = 5'd0;
        state_nxt = tgdt_pkg::S_SQ_ITER;
      end
      tgdt_pkg::S_SQ_ITER: begin
        cmd.op = tgdt_pkg::OP_SQ_ITER;
        step_nxt = step_r + 5'd1;
        if (step_r == tgdt_pkg::SQRT_LAST) state_nxt = tgdt_pkg::S_SP_ACC;
      end
      tgdt_pkg::S_SP_ACC: begin
        cmd.op = tgdt_pkg::OP_SP_ACC;
        if ({1'b0, fi_r} == status.c - 3'd2) state_nxt = tgdt_pkg::S_DIV_INIT;
        else begin
          fi_nxt = fi_r + 2'd1;
          state_nxt = tgdt_pkg::S_SP_DIFF;
        end
      end
      tgdt_pkg::S_DIV_INIT: begin
        cmd.op = tgdt_pkg::OP_DIV_INIT;
        step_nxt = 5'd0;
        state_nxt = tgdt_pkg::S_DIV_ITER;
      end
      tgdt_pkg::S_DIV_ITER: begin
        cmd.op = tgdt_pkg::OP_DIV_ITER;
        step_nxt = step_r + 5'd1;
        if (step_r == tgdt_pkg::DIV_LAST) state_nxt = tgdt_pkg::S_PX_M;
      end
      tgdt_pkg::S_PX_M: begin
        cmd.op = tgdt_pkg::OP_PX_M;
        state_nxt = tgdt_pkg::S_DECIDE;
      end
      tgdt_pkg::S_DECIDE: begin
        cmd.op = tgdt_pkg::OP_DECIDE;
        state_nxt = tgdt_pkg::S_EMIT;
      end
      tgdt_pkg::S_EMIT: begin
        if (status.out_free) begin
          cmd.op = tgdt_pkg::OP_EMIT;
          state_nxt = tgdt_pkg::S_IDLE;
        end
      end
      default: state_nxt = tgdt_pkg::S_IDLE;
    endcase
  end
endmodule

FILE: rtl/touch_gesture_direction_tracker_unit.sv
// Top level of the touch gesture direction tracker.
// Input stream: one request per touch frame or clear command (in_tuser = clear).
// Each request gives exactly one result on the output stream.
// Configuration: cfg_we writes register cfg_idx with cfg_wdata;
// write only while no request is in flight.
// A clear goes straight to its result; a skipped frame runs one multiply step
// per tracked finger plus one. A four-finger frame takes longest: it runs the
// per-finger 16-step CORDIC and the 24-step square root on each adjacent finger
// pair, plus a 25-step divide for the mean spacing; one request is worked at a
// time.
// The result sits in an output register, so the next request is taken while
// a finished result waits; a stalled receiver holds the block only when the
// next result is ready to be written.
// Reset (synchronous, active low) clears the tracking history, positions, zones
// and counters, loads the register defaults and empties the output register.
module touch_gesture_direction_tracker_unit #(
  parameter int MAX_MOVES = tgdt_pkg::MAX_MOVES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // finger_count, finger0_x, finger0_y, ... finger3_x, finger3_y, zero pad
  input  logic [135:0] in_tdata,
  // cmd
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // accepted, move_valid, move_code, tracked_fingers, start_x, start_y,
  // sequence_length, sequence_full, zero pad
  output logic [47:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_idx,
  input  logic [9:0]   cfg_wdata
);
  tgdt_pkg::dp_cmd_t    cmd;
  tgdt_pkg::dp_status_t status;

  tgdt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .status(status), .cmd(cmd)
  );

  tgdt_datapath #(.MAX_MOVES(MAX_MOVES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .in_cmd(in_tuser), .in_frame(in_tdata[130:0]),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );
endmodule

FILE: rtl/tgdt_checker.sv
// Port-level checker for the tracker, bound to the top level.
`include "assert_macros.svh"
module tgdt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  `TGDT_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  `TGDT_ASSERT_IMP(a_move_acc, clk, rst_n, out_tvalid && out_tdata[1], out_tdata[0], "move without accept")
  `TGDT_ASSERT_IMP(a_full, clk, rst_n, out_tvalid && out_tdata[46], out_tdata[0] && !out_tdata[1], "bad full flag")
  `TGDT_ASSERT_IMP(a_code0, clk, rst_n, out_tvalid && !out_tdata[1], out_tdata[5:2] == 4'd0, "stray move code")
endmodule

bind touch_gesture_direction_tracker_unit tgdt_checker u_tgdt_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
